// File: sv/tpm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpm_pkg: shared constants, types and helpers
// Sizes of the page directory and page tables, index widths and the
// controller state encoding.
// ---------------------------------------------------------------------------
package tpm_pkg;

	localparam int unsigned DIR_ENTRIES   = 1024;
	localparam int unsigned TABLE_ENTRIES = 1024;

	localparam int unsigned DIR_W   = $clog2(DIR_ENTRIES);
	localparam int unsigned TBL_W   = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W   = (DIR_W > TBL_W) ? DIR_W : TBL_W;
	localparam int unsigned SLOT_W  = DIR_W + TBL_W;
	localparam int unsigned HALF_W  = 10;
	localparam int unsigned FRAME_W = 20;
	localparam int unsigned VPN_W   = 20;
	// page entry as stored: frame above the present bit
	localparam int unsigned PTE_W   = FRAME_W + 1;

	// reciprocal constants for index reduction: rcp = ceil(2^sh / n),
	// sh = HALF_W + clog2(n), exact for every HALF_W-bit index
	localparam int unsigned DIR_SH  = HALF_W + $clog2(DIR_ENTRIES);
	localparam int unsigned DIR_RCP = ((32'd1 << DIR_SH) + DIR_ENTRIES - 1) / DIR_ENTRIES;
	localparam int unsigned TBL_SH  = HALF_W + $clog2(TABLE_ENTRIES);
	localparam int unsigned TBL_RCP = ((32'd1 << TBL_SH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;

	localparam logic CMD_MAP   = 1'b0;
	localparam logic CMD_UNMAP = 1'b1;

	typedef enum logic [6:0] {
		ST_CLR_DIR = 7'b000_0001,
		ST_IDLE    = 7'b000_0010,
		ST_IDX     = 7'b000_0100,
		ST_RD_DIR  = 7'b000_1000,
		ST_RD_TBL  = 7'b001_0000,
		ST_CLR_TBL = 7'b010_0000,
		ST_OUT     = 7'b100_0000
	} state_t;

	// x mod n by reciprocal multiplication: quotient from one constant
	// multiply and shift, remainder from one constant multiply and subtract
	function automatic logic [HALF_W-1:0] reduce_idx(input logic [HALF_W-1:0] x,
			input int unsigned n, input int unsigned rcp, input int unsigned sh);
		logic [31:0] q;
		q = (32'(x) * rcp) >> sh;
		return HALF_W'(32'(x) - q * 32'(n));
	endfunction

endpackage
`default_nettype wire

// File: sv/tpm_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpm_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tpm_ram #(
	parameter int unsigned ADDR_W = 10,
	parameter int unsigned DATA_W = 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/two_level_page_map_unmap.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_level_page_map_unmap: two-level page directory / page table keeper
// Serves map and unmap requests against a directory RAM and a table RAM.
// ---------------------------------------------------------------------------
// Each request is handled alone. A map or unmap whose page table already
// exists passes through index reduction, directory read, table read
// (read-modify-write on the table RAM) and the output load, in that order;
// the two RAM reads are dependent, and the output load waits while an
// earlier result still sits untaken in the output register. Once the result
// is loaded, the next request can be accepted. A map that creates a new
// table sweeps the table RAM once over all TABLE_ENTRIES entries of the new
// table, one per cycle, writing the new page entry in the same pass. After
// reset the directory RAM is cleared in one pass over all DIR_ENTRIES
// entries, during which no request is accepted. A new request is accepted
// while the previous result still waits in the output register. Only the
// present bit and frame number of page entries are held; flag bits follow
// from the page number and are never reported, so the directory keeps just
// its present bits.
module two_level_page_map_unmap (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// s_axis_tdata, from bit 0: virt_page[19:0], table_frame[39:20],
	// page_frame[59:40], zero pad[63:60]
	input  wire logic [63:0] s_axis_tdata,
	// s_axis_tuser: cmd[0] (0 map, 1 unmap)
	input  wire logic        s_axis_tuser,
	// result channel
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// m_axis_tdata, from bit 0: ok[0], took_table_frame[1],
	// took_page_frame[2], freed_frame[22:3], zero pad[23]
	output logic      [23:0] m_axis_tdata
);

	localparam int unsigned DIR_W  = tpm_pkg::DIR_W;
	localparam int unsigned TBL_W  = tpm_pkg::TBL_W;
	localparam int unsigned CNT_W  = tpm_pkg::CNT_W;
	localparam int unsigned SLOT_W = tpm_pkg::SLOT_W;
	localparam int unsigned HALF_W = tpm_pkg::HALF_W;
	localparam int unsigned FRAME_W = tpm_pkg::FRAME_W;
	localparam int unsigned VPN_W  = tpm_pkg::VPN_W;
	localparam int unsigned PTE_W  = tpm_pkg::PTE_W;

	tpm_pkg::state_t state_q;

	// latched request
	logic               cmd_q;
	logic [VPN_W-1:0]   vpn_q;
	logic [FRAME_W-1:0] pframe_q;
	logic [DIR_W-1:0]   dix_q;
	logic [TBL_W-1:0]   tix_q;
	logic [CNT_W-1:0]   cnt_q;

	// pending result
	logic               res_ok_q;
	logic               res_tt_q;
	logic               res_tp_q;
	logic [FRAME_W-1:0] res_freed_q;

	// output register
	logic               out_valid_q;
	logic [23:0]        out_data_q;

	logic               in_acc;
	logic               out_load;
	logic               cnt_dir_last;
	logic               cnt_tbl_last;
	logic [DIR_W-1:0]   dix_next;
	logic [TBL_W-1:0]   tix_next;

	// RAM ports
	logic               dir_we;
	logic [DIR_W-1:0]   dir_waddr;
	logic               dir_wdata;
	logic               dir_rdata;
	logic               tbl_we;
	logic [SLOT_W-1:0]  tbl_waddr;
	logic [PTE_W-1:0]   tbl_wdata;
	logic [PTE_W-1:0]   tbl_rdata;

	assign s_axis_tready = (state_q == tpm_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == tpm_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign cnt_dir_last = (cnt_q[DIR_W-1:0] == DIR_W'(tpm_pkg::DIR_ENTRIES - 1));
	assign cnt_tbl_last = (cnt_q[TBL_W-1:0] == TBL_W'(tpm_pkg::TABLE_ENTRIES - 1));

	// directory and table indices, reduced to the configured sizes
	assign dix_next = DIR_W'(tpm_pkg::reduce_idx(vpn_q[VPN_W-1:HALF_W], tpm_pkg::DIR_ENTRIES,
		tpm_pkg::DIR_RCP, tpm_pkg::DIR_SH));
	assign tix_next = TBL_W'(tpm_pkg::reduce_idx(vpn_q[HALF_W-1:0], tpm_pkg::TABLE_ENTRIES,
		tpm_pkg::TBL_RCP, tpm_pkg::TBL_SH));

	// RAM write steering
	always_comb begin
		dir_we    = 1'b0;
		dir_waddr = dix_q;
		dir_wdata = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = {dix_q, tix_q};
		tbl_wdata = '0;
		unique case (state_q)
			tpm_pkg::ST_CLR_DIR: begin
				dir_we    = 1'b1;
				dir_waddr = cnt_q[DIR_W-1:0];
			end
			tpm_pkg::ST_RD_DIR: begin
				// new table: mark directory entry present
				if (cmd_q == tpm_pkg::CMD_MAP && !dir_rdata) begin
					dir_we    = 1'b1;
					dir_wdata = 1'b1;
				end
			end
			tpm_pkg::ST_CLR_TBL: begin
				// clear the new table; the requested slot gets its entry in the same pass
				tbl_we    = 1'b1;
				tbl_waddr = {dix_q, cnt_q[TBL_W-1:0]};
				if (cnt_q[TBL_W-1:0] == tix_q) begin
					tbl_wdata = {pframe_q, 1'b1};
				end
			end
			tpm_pkg::ST_RD_TBL: begin
				if (cmd_q == tpm_pkg::CMD_MAP) begin
					if (!tbl_rdata[0]) begin
						tbl_we    = 1'b1;
						tbl_wdata = {pframe_q, 1'b1};
					end
				end else if (dir_rdata && tbl_rdata[0]) begin
					tbl_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	tpm_ram #(
		.ADDR_W (DIR_W),
		.DATA_W (1)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr (dix_next),
		.rdata (dir_rdata)
	);

	tpm_ram #(
		.ADDR_W (SLOT_W),
		.DATA_W (PTE_W)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr ({dix_q, tix_q}),
		.rdata (tbl_rdata)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpm_pkg::ST_CLR_DIR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				tpm_pkg::ST_CLR_DIR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_dir_last) begin
						state_q <= tpm_pkg::ST_IDLE;
					end
				end
				tpm_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= tpm_pkg::ST_IDX;
					end
				end
				tpm_pkg::ST_IDX: begin
					// directory read issued here
					state_q <= tpm_pkg::ST_RD_DIR;
				end
				tpm_pkg::ST_RD_DIR: begin
					cnt_q <= '0;
					if (cmd_q == tpm_pkg::CMD_MAP && !dir_rdata) begin
						state_q <= tpm_pkg::ST_CLR_TBL;
					end else begin
						state_q <= tpm_pkg::ST_RD_TBL;
					end
				end
				tpm_pkg::ST_CLR_TBL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_tbl_last) begin
						state_q <= tpm_pkg::ST_OUT;
					end
				end
				tpm_pkg::ST_RD_TBL: begin
					state_q <= tpm_pkg::ST_OUT;
				end
				tpm_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= tpm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tpm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request capture and result build-up
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= s_axis_tuser;
			vpn_q    <= s_axis_tdata[19:0];
			pframe_q <= s_axis_tdata[59:40];
		end
		if (state_q == tpm_pkg::ST_IDX) begin
			dix_q <= dix_next;
			tix_q <= tix_next;
		end
		unique case (state_q)
			tpm_pkg::ST_RD_DIR: begin
				// a fresh table always takes the page
				res_ok_q    <= (cmd_q == tpm_pkg::CMD_MAP) && !dir_rdata;
				res_tt_q    <= (cmd_q == tpm_pkg::CMD_MAP) && !dir_rdata;
				res_tp_q    <= (cmd_q == tpm_pkg::CMD_MAP) && !dir_rdata;
				res_freed_q <= '0;
			end
			tpm_pkg::ST_RD_TBL: begin
				if (cmd_q == tpm_pkg::CMD_MAP) begin
					res_ok_q <= !tbl_rdata[0];
					res_tp_q <= !tbl_rdata[0];
				end else if (dir_rdata && tbl_rdata[0]) begin
					res_ok_q    <= 1'b1;
					res_freed_q <= tbl_rdata[PTE_W-1:1];
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {1'b0, res_freed_q, res_tp_q, res_tt_q, res_ok_q};
		end
	end

	// checks
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpm_pkg::ST_CLR_DIR) |-> !s_axis_tready)
		else $error("request accepted during directory clear");

	a_accept_to_idx: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == tpm_pkg::ST_IDX))
		else $error("accepted request did not start index stage");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpm_pkg::ST_CLR_TBL && cnt_tbl_last) |=> (state_q == tpm_pkg::ST_OUT))
		else $error("table sweep did not end in result");

	a_freed_only_unmap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[22:3] != '0) |-> (out_data_q[0] && !out_data_q[1]
			&& !out_data_q[2]))
		else $error("freed frame on a result that is not a successful unmap");

	a_new_table_maps: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (!out_data_q[1] || (out_data_q[0] && out_data_q[2])))
		else $error("new table without mapped page");

endmodule
`default_nettype wire

// File: dv/page_map_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// page_map_checker: request/reply tracker for the page map block
// Predicts the reply to every accepted request from its own copy of the
// directory and page tables, and compares each accepted reply with it.
// ---------------------------------------------------------------------------
module page_map_checker
	import tpm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_ready,
	// req_data, from bit 0: virt_page[19:0], table_frame[39:20],
	// page_frame[59:40], zero pad[63:60]
	input  wire logic [63:0] req_data,
	// req_cmd: cmd[0]
	input  wire logic        req_cmd,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_ready,
	// rsp_data, from bit 0: ok[0], took_table_frame[1], took_page_frame[2],
	// freed_frame[22:3], zero pad[23]
	input  wire logic [23:0] rsp_data,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic               ok;
		logic               took_table;
		logic               took_page;
		logic [FRAME_W-1:0] freed;
	} reply_t;

	bit               dir_present [DIR_ENTRIES];
	// {frame, present}; a missing key is a cleared entry
	logic [FRAME_W:0] page_slot [int unsigned];
	reply_t           awaited_replies [$];
	int               errors;

	// Flags (kernel or user) are never reported, so only present bit and
	// frame are kept.
	function automatic reply_t serve_request(input logic cmd,
			input logic [VPN_W-1:0] vpage, input logic [FRAME_W-1:0] tframe,
			input logic [FRAME_W-1:0] pframe);
		reply_t           r;
		int unsigned      d;
		int unsigned      t;
		int unsigned      base;
		int unsigned      slot;
		logic [FRAME_W:0] pte;
		r    = '0;
		d    = 32'(vpage[VPN_W-1:HALF_W]) % DIR_ENTRIES;
		t    = 32'(vpage[HALF_W-1:0]) % TABLE_ENTRIES;
		base = d * TABLE_ENTRIES;
		slot = base + t;
		pte  = page_slot.exists(slot) ? page_slot[slot] : '0;
		if (cmd == CMD_MAP) begin
			if (!dir_present[d]) begin
				// new table from tframe: every entry starts cleared
				dir_present[d] = 1'b1;
				for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
					page_slot.delete(base + i);
				end
				r.took_table = 1'b1;
				pte = '0;
			end
			if (!pte[0]) begin
				page_slot[slot] = {pframe, 1'b1};
				r.ok        = 1'b1;
				r.took_page = 1'b1;
			end
		end else if (dir_present[d] && pte[0]) begin
			r.freed = pte[FRAME_W:1];
			page_slot.delete(slot);
			r.ok = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			foreach (dir_present[i]) dir_present[i] = 1'b0;
			page_slot.delete();
			awaited_replies.delete();
			errors = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// replies first: one accepted on this edge belongs to an older request
			if (rsp_valid && rsp_ready) begin
				got = {rsp_data[0], rsp_data[1], rsp_data[2], rsp_data[22:3]};
				if (awaited_replies.size() == 0) begin
					$display("%0t: reply with no request waiting: ok=%0b table=%0b page=%0b freed=%05h",
						$time, got.ok, got.took_table, got.took_page, got.freed);
					errors++;
				end else begin
					want = awaited_replies.pop_front();
					if (got !== want) begin
						$display("%0t: reply mismatch: expected ok=%0b table=%0b page=%0b freed=%05h",
							$time, want.ok, want.took_table, want.took_page, want.freed);
						$display("%0t:                 actual   ok=%0b table=%0b page=%0b freed=%05h",
							$time, got.ok, got.took_table, got.took_page, got.freed);
						errors++;
					end
				end
			end
			if (req_valid && req_ready) begin
				awaited_replies.push_back(serve_request(req_cmd, req_data[19:0],
					req_data[39:20], req_data[59:40]));
			end
			fail_count  <= errors;
			outstanding <= awaited_replies.size();
		end
	end

endmodule
`default_nettype wire

// File: dv/two_level_page_map_unmap_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_level_page_map_unmap_tb: top of the page map testbench
// Drives map and unmap requests with random gaps on both channels; the
// checker beside the block predicts and compares every reply.
// ---------------------------------------------------------------------------
// Flow:
//   - reset first; the block then clears its directory on its own,
//     holding s_axis_tready low, so the first request simply waits.
//   - a short directed list: unmap with no table, map that builds a table,
//     map of a mapped page, unmap of a mapped and of an unmapped page, the
//     corners of the page number (last user page, first kernel page, top
//     page) and frames at zero and all ones.
//   - three random phases: sender idle 9% / receiver idle 71%, then the
//     reverse, then no idling at all. The last phase opens with a long
//     receiver hold-off so that the block backs up and stalls its input.
// Random page numbers mostly fall in a handful of hot directories so that
// maps and unmaps collide; a new table costs a sweep over all TABLE_ENTRIES
// entries, so fresh directories are kept rare.
module two_level_page_map_unmap_tb;
	import tpm_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 12000; // quiet cycles before giving up
	localparam int unsigned DRAIN_CYCLES    = 40;
	localparam int unsigned ITEMS_PER_PHASE = 400;
	localparam int unsigned HOLD_CYCLES     = 400;

	logic        clk = 1'b0;
	logic        arst_n;

	logic        s_axis_tvalid;
	wire         s_axis_tready;
	// s_axis_tdata, from bit 0: virt_page[19:0], table_frame[39:20],
	// page_frame[59:40], zero pad[63:60]
	logic [63:0] s_axis_tdata;
	// s_axis_tuser: cmd[0]
	logic        s_axis_tuser;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// m_axis_tdata, from bit 0: ok[0], took_table_frame[1],
	// took_page_frame[2], freed_frame[22:3], zero pad[23]
	wire  [23:0] m_axis_tdata;

	int          fail_count;
	int          outstanding;
	int          tx_idle_pct = 9;
	int          rx_idle_pct = 71;
	logic        hold_go     = 1'b0;
	int          hold_left   = 0;
	bit          hold_done   = 1'b0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	two_level_page_map_unmap DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	page_map_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_data    (s_axis_tdata),
		.req_cmd     (s_axis_tuser),
		.rsp_valid   (m_axis_tvalid),
		.rsp_ready   (m_axis_tready),
		.rsp_data    (m_axis_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Receiver: random back-pressure, plus one long hold-off counted here
	// once the stimulus raises hold_go.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			hold_done     <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Watchdog: any accepted request or reply restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d replies outstanding", $time, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one request, with a random run of idle cycles in front; returns
	// on the edge at which it is accepted. tvalid stays high into the next
	// request when no gap follows.
	task automatic send_request(input logic cmd, input logic [VPN_W-1:0] vpage,
			input logic [FRAME_W-1:0] tframe, input logic [FRAME_W-1:0] pframe);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'b0000, pframe, tframe, vpage};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Page number: mostly hot directories (both sides of the kernel split,
	// first and last entry) and low table slots, now and then anything.
	function automatic logic [VPN_W-1:0] pick_page();
		logic [HALF_W-1:0] d;
		logic [HALF_W-1:0] t;
		int unsigned       r;
		r = $urandom_range(0, 99);
		if (r < 95) begin
			case ($urandom_range(0, 7))
				0:       d = 10'h000;
				1:       d = 10'h001;
				2:       d = 10'h155;
				3:       d = 10'h2aa;
				4:       d = 10'h2ff; // last user directory
				5:       d = 10'h300; // first kernel directory
				6:       d = 10'h301;
				default: d = 10'h3ff;
			endcase
		end else begin
			d = HALF_W'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			t = HALF_W'($urandom_range(0, 7));
		end else if (r < 85) begin
			t = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
		end else begin
			t = HALF_W'($urandom);
		end
		return {d, t};
	endfunction

	initial begin
		int                phase_items;
		int unsigned       kind;
		logic [VPN_W-1:0]  vpage;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_MAP;
		@(posedge arst_n);
		@(posedge clk);

		// directed requests
		send_request(CMD_UNMAP, 20'h00000, 20'h00000, 20'h00000); // no table yet
		send_request(CMD_MAP,   20'h00000, 20'h00001, 20'h00002); // builds a table
		send_request(CMD_MAP,   20'h00000, 20'hfffff, 20'hfffff); // already mapped
		send_request(CMD_UNMAP, 20'h00000, 20'hfffff, 20'hfffff); // frees frame 2
		send_request(CMD_UNMAP, 20'h00000, 20'h00000, 20'h00000); // table, no page
		send_request(CMD_MAP,   20'h003ff, 20'h12345, 20'h00000); // last slot, frame 0
		send_request(CMD_UNMAP, 20'h003ff, 20'h00000, 20'h00000); // frees frame 0
		send_request(CMD_MAP,   20'hfffff, 20'hfffff, 20'hfffff); // top kernel page
		send_request(CMD_MAP,   20'hffc00, 20'h00000, 20'h0f0f0);
		send_request(CMD_MAP,   20'hc0000, 20'h00000, 20'haaaaa); // first kernel page
		send_request(CMD_MAP,   20'hbffff, 20'h55555, 20'h55555); // last user page
		send_request(CMD_UNMAP, 20'hfffff, 20'h00000, 20'h00000);
		send_request(CMD_UNMAP, 20'hc0000, 20'h00000, 20'h00000);
		send_request(CMD_UNMAP, 20'hbffff, 20'h00000, 20'h00000);
		send_request(CMD_UNMAP, 20'hc0000, 20'hfffff, 20'hfffff); // unmapped again
		send_request(CMD_UNMAP, 20'h7fc00, 20'h00000, 20'h00000); // no table
		send_request(CMD_MAP,   20'h003ff, 20'h00000, 20'hfffff); // remap after unmap
		send_request(CMD_UNMAP, 20'hffc00, 20'h00000, 20'h00000);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct  = 9;
					rx_idle_pct <= 71;
				end
				1: begin
					tx_idle_pct  = 71;
					rx_idle_pct <= 9;
				end
				default: begin
					tx_idle_pct  = 0;
					rx_idle_pct <= 0;
					hold_go     <= 1'b1; // long hold-off while requests keep coming
				end
			endcase
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				kind  = $urandom_range(0, 99);
				vpage = pick_page();
				if (kind < 55) begin
					send_request(1'($urandom_range(0, 1)), vpage, 20'($urandom), 20'($urandom));
					phase_items++;
				end else if (kind < 95) begin
					// map, sometimes a repeat map, then unmap of the same page
					send_request(CMD_MAP, vpage, 20'($urandom), 20'($urandom));
					if ($urandom_range(0, 3) == 0) begin
						send_request(CMD_MAP, vpage, 20'($urandom), 20'($urandom));
						phase_items++;
					end
					send_request(CMD_UNMAP, vpage, 20'($urandom), 20'($urandom));
					phase_items += 2;
				end else begin
					// anything at all
					send_request(1'($urandom_range(0, 1)), 20'($urandom), 20'($urandom),
						20'($urandom));
					phase_items++;
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		// let the last request show in outstanding first
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
